>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

>>> hw/rtl/tfd_pkg.sv
// ---------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the typed frame deframer.
// ---------------------------------------------------------------------------
package tfd_pkg;

   localparam int PAYLOAD_MAX = 32;
   localparam int RAW_LEN     = 67;

   localparam int RAW_CNT_W = $clog2(RAW_LEN);
   localparam int PAY_CNT_W = $clog2(PAYLOAD_MAX + 1);
   localparam int INDEX_W   = 5;

   typedef enum logic [2:0] {
      PH_START,
      PH_TYPE,
      PH_ACCEPT,
      PH_ESCAPE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_START,
      ST_START_IN_PAYLOAD,
      ST_OVERFLOW
   } status_type;

   typedef enum logic [1:0] {
      CSR_START_BYTE,
      CSR_END_BYTE,
      CSR_ESCAPE_BYTE,
      CSR_XOR_MASK
   } csr_index_type;

   localparam logic [7:0] START_BYTE_RST  = 8'd2;
   localparam logic [7:0] END_BYTE_RST    = 8'd3;
   localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;
   localparam logic [7:0] XOR_MASK_RST    = 8'd32;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
      logic [7:0] escape_byte;
      logic [7:0] xor_mask;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic [RAW_CNT_W-1:0]   raw_count;
      logic [PAY_CNT_W-1:0]   payload_count;
      logic [7:0]             type_hold;
      status_type             error_code;
   } chunk_state_type;

   typedef struct packed {
      logic               data_valid;
      logic [7:0]         data_byte;
      logic [INDEX_W-1:0] data_index;
      logic               frame_done;
      logic [7:0]         frame_kind;
      status_type         status;
   } result_type;

endpackage

>>> hw/rtl/typed_frame_deframer.sv
// ---------------------------------------------------------------------------
// typed_frame_deframer
// Byte-stuffing deframer for fixed-length chunks carrying a typed frame.
// ---------------------------------------------------------------------------
// A result beat is registered and appears in the cycle after its raw byte.
// Throughput: one raw byte per cycle, set by the single decode stage feeding
// the result register; a byte is taken while a result waits if it is drained.
// Reset (synchronous, active high) restores the register defaults and starts
// a fresh chunk expecting the start byte; the result register is emptied.
`include "assert_macros.svh"

module typed_frame_deframer import tfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // raw byte channel
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   // decoded result channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_data_valid,
   output logic [7:0]   rsp_data_byte,
   output logic [4:0]   rsp_data_index,
   output logic         rsp_frame_done,
   output logic [7:0]   rsp_frame_kind,
   output logic [1:0]   rsp_status,
   // configuration writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   chunk_state_type state_ff;
   chunk_state_type state_in;
   result_type      rsp_ff;
   result_type      rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      step_result;
   logic            step_present;
   logic            req_accept;

   // -------------------------------------------------------------------------
   // Configuration registers. A write is taken at once and applies to the
   // next byte decoded.
   // -------------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BYTE:  cfg_in.start_byte  = csr_wdata;
            CSR_END_BYTE:    cfg_in.end_byte    = csr_wdata;
            CSR_ESCAPE_BYTE: cfg_in.escape_byte = csr_wdata;
            CSR_XOR_MASK:    cfg_in.xor_mask    = csr_wdata;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte  <= START_BYTE_RST;
         cfg_ff.end_byte    <= END_BYTE_RST;
         cfg_ff.escape_byte <= ESCAPE_BYTE_RST;
         cfg_ff.xor_mask    <= XOR_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // -------------------------------------------------------------------------
   // Decode. The chunk state and the incoming byte give the next state and a
   // possible result beat in one pass of logic.
   // -------------------------------------------------------------------------
   tfd_step u_step (
      .cfg            (cfg_ff),
      .state          (state_ff),
      .rx_byte        (req_rx_byte),
      .state_in       (state_in),
      .result         (step_result),
      .result_present (step_present)
   );

   // -------------------------------------------------------------------------
   // Handshake. A new byte is taken whenever the result register is empty or
   // is being drained in the same cycle, so bytes can stream back to back.
   // Bytes that produce no result only advance the chunk state.
   // -------------------------------------------------------------------------
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && step_present) begin
         rsp_in       = step_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_START;
         state_ff.raw_count     <= '0;
         state_ff.payload_count <= '0;
         state_ff.type_hold     <= 8'd0;
         state_ff.error_code    <= ST_OK;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_valid = rsp_ff.data_valid;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_data_index = rsp_ff.data_index;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_frame_kind = rsp_ff.frame_kind;
   assign rsp_status     = rsp_ff.status;

   // -------------------------------------------------------------------------
   // Checks
   // -------------------------------------------------------------------------
   `ASSERT_NEVER(a_status_without_done, clock, reset,
      rsp_valid_ff && !rsp_ff.frame_done && rsp_ff.status != ST_OK)
   `ASSERT_NEVER(a_type_on_error, clock, reset,
      rsp_valid_ff && rsp_ff.status != ST_OK && rsp_ff.frame_kind != 8'd0)
   `ASSERT_CLK(a_chunk_restarts, clock, reset,
      req_accept && state_ff.raw_count == RAW_CNT_W'(RAW_LEN - 1)
      |=> state_ff.phase == PH_START && state_ff.payload_count == '0)
   `ASSERT_NEVER(a_count_bounds, clock, reset,
      state_ff.payload_count > PAY_CNT_W'(PAYLOAD_MAX) ||
      state_ff.raw_count > RAW_CNT_W'(RAW_LEN - 1))

endmodule

>>> hw/rtl/tfd_step.sv
// ---------------------------------------------------------------------------
// tfd_step
// Decodes one raw byte against the chunk state: next state and result beat.
// ---------------------------------------------------------------------------
module tfd_step import tfd_pkg::*; (
   input  cfg_type         cfg,
   input  chunk_state_type state,
   input  logic [7:0]      rx_byte,
   output chunk_state_type state_in,
   output result_type      result,
   output logic            result_present
);

   logic       emit;
   logic [7:0] emit_byte;
   logic       overflow;
   logic       last;
   logic       stored;

   assign last     = (state.raw_count == RAW_CNT_W'(RAW_LEN - 1));
   assign overflow = (state.payload_count >= PAY_CNT_W'(PAYLOAD_MAX));

   // Output side: which byte, if any, leaves for this beat.
   always_comb begin
      emit      = 1'b0;
      emit_byte = rx_byte;
      unique case (state.phase)
         PH_ACCEPT: begin
            emit = (rx_byte != cfg.start_byte) && (rx_byte != cfg.end_byte) &&
                   (rx_byte != cfg.escape_byte);
         end
         PH_ESCAPE: begin
            emit      = 1'b1;
            emit_byte = rx_byte ^ cfg.xor_mask;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign stored = emit && !overflow;

   // Next state of the chunk.
   always_comb begin
      chunk_state_type nxt;
      nxt           = state;
      nxt.raw_count = state.raw_count + RAW_CNT_W'(1);
      unique case (state.phase)
         PH_START: begin
            if (rx_byte != cfg.start_byte) begin
               nxt.error_code = ST_BAD_START;
               nxt.phase      = PH_DONE;
            end else begin
               nxt.phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            nxt.type_hold = rx_byte;
            nxt.phase     = PH_ACCEPT;
         end
         PH_ACCEPT: begin
            priority if (rx_byte == cfg.start_byte) begin
               nxt.error_code = ST_START_IN_PAYLOAD;
               nxt.phase      = PH_DONE;
            end else if (rx_byte == cfg.end_byte) begin
               nxt.phase = PH_DONE;
            end else if (rx_byte == cfg.escape_byte) begin
               nxt.phase = PH_ESCAPE;
            end
         end
         PH_ESCAPE: begin
            nxt.phase = PH_ACCEPT;
         end
         default: begin
            nxt.phase = state.phase;
         end
      endcase

      if (emit && overflow) begin
         nxt.error_code = ST_OVERFLOW;
         nxt.phase      = PH_DONE;
      end
      if (stored) begin
         nxt.payload_count = state.payload_count + PAY_CNT_W'(1);
      end

      result.data_valid = stored;
      result.data_byte  = stored ? emit_byte : 8'd0;
      result.data_index = stored ? INDEX_W'(state.payload_count) : '0;
      result.frame_done = last;
      result.frame_kind = (last && nxt.error_code == ST_OK) ? nxt.type_hold : 8'd0;
      result.status     = last ? nxt.error_code : ST_OK;

      // The chunk ends here whatever state it was in.
      if (last) begin
         nxt.phase         = PH_START;
         nxt.raw_count     = '0;
         nxt.payload_count = '0;
         nxt.type_hold     = 8'd0;
         nxt.error_code    = ST_OK;
      end
      state_in = nxt;
   end

   assign result_present = stored || last;

endmodule

>>> bench/tb_typed_frame_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_typed_frame_deframer
// Self-checking bench for the typed frame deframer. Raw chunks are streamed
// into the byte channel. Each accepted beat is decoded by a behavioural copy
// of the deframer, and every result beat is compared field by field with the
// oldest decode still owed. Directed chunks cover the corner cases; random
// chunks under several register settings follow, with random stalls on both
// channels.
// ---------------------------------------------------------------------------
module tb_typed_frame_deframer;
   import tfd_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   // Behavioural deframer plus the queue of result beats it still owes.
   class deframe_tracker;
      cfg_type    cfg;
      result_type owed_results[$];
      phase_type  stage;
      status_type fault;
      int         raw_seen;
      int         payload_seen;
      logic [7:0] held_type;
      int         errors;
      int         raw_bytes;
      int         decoded_bytes;
      int         data_beats;
      int         frame_reports;
      int         status_count[4];

      function new();
         cfg = {START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, XOR_MASK_RST};
         restart_chunk();
      endfunction

      function void restart_chunk();
         stage        = PH_START;
         fault        = ST_OK;
         raw_seen     = 0;
         payload_seen = 0;
         held_type    = 8'h00;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] v);
         case (idx)
            CSR_START_BYTE:  cfg.start_byte  = v;
            CSR_END_BYTE:    cfg.end_byte    = v;
            CSR_ESCAPE_BYTE: cfg.escape_byte = v;
            CSR_XOR_MASK:    cfg.xor_mask    = v;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      // Decode one accepted raw byte and queue the result beat, if any, it causes.
      function void note_raw_byte(logic [7:0] b);
         result_type r;
         logic       emit;
         logic [7:0] val;
         logic       last;
         r    = '0;
         emit = 1'b0;
         val  = 8'h00;
         last = (raw_seen + 1 >= RAW_LEN);
         raw_bytes++;
         if (stage != PH_DONE)
            decoded_bytes++;
         case (stage)
            PH_START: begin
               if (b != cfg.start_byte) begin
                  fault = ST_BAD_START;
                  stage = PH_DONE;
               end else begin
                  stage = PH_TYPE;
               end
            end
            PH_TYPE: begin
               held_type = b;
               stage     = PH_ACCEPT;
            end
            PH_ACCEPT: begin
               // The start byte takes priority over the end and escape bytes.
               if (b == cfg.start_byte) begin
                  fault = ST_START_IN_PAYLOAD;
                  stage = PH_DONE;
               end else if (b == cfg.end_byte) begin
                  stage = PH_DONE;
               end else if (b == cfg.escape_byte) begin
                  stage = PH_ESCAPE;
               end else begin
                  emit = 1'b1;
                  val  = b;
               end
            end
            PH_ESCAPE: begin
               emit  = 1'b1;
               val   = b ^ cfg.xor_mask;
               stage = PH_ACCEPT;
            end
            default: ;
         endcase
         if (emit) begin
            if (payload_seen >= PAYLOAD_MAX) begin
               fault = ST_OVERFLOW;
               stage = PH_DONE;
            end else begin
               r.data_valid = 1'b1;
               r.data_byte  = val;
               r.data_index = INDEX_W'(payload_seen);
               payload_seen++;
            end
         end
         if (last) begin
            r.frame_done = 1'b1;
            r.frame_kind = (fault == ST_OK) ? held_type : 8'h00;
            r.status     = fault;
            restart_chunk();
            owed_results.push_back(r);
         end else begin
            raw_seen++;
            if (r.data_valid)
               owed_results.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            $error("result beat arrived with nothing owed: 0x%0h", got);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
         compare_field("data_byte",  want.data_byte,      got.data_byte);
         compare_field("data_index", 8'(want.data_index), 8'(got.data_index));
         compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
         compare_field("frame_kind", want.frame_kind,     got.frame_kind);
         compare_field("status",     8'(want.status),     8'(got.status));
         if (want.data_valid)
            data_beats++;
         if (want.frame_done) begin
            frame_reports++;
            status_count[want.status]++;
         end
      endfunction

      function void close_out();
         if (owed_results.size() != 0) begin
            $error("%0d result beats never arrived", owed_results.size());
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic [4:0] rsp_data_index;
   logic       rsp_frame_done;
   logic [7:0] rsp_frame_kind;
   logic [1:0] rsp_status;
   logic       csr_we    = 1'b0;
   logic [1:0] csr_index = 2'b00;
   logic [7:0] csr_wdata = 8'h00;

   deframe_tracker tracker = new();

   // The bench's own view of the registers, used only to build chunks.
   cfg_type cur_cfg = {START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, XOR_MASK_RST};

   // When set, neither side idles or stalls.
   logic quiet = 1'b0;

   int chunks_sent   = 0;
   int settings_used = 1;

   typed_frame_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_valid (rsp_data_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_index (rsp_data_index),
      .rsp_frame_done (rsp_frame_done),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A payload byte that none of the control bytes will claim.
   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      do
         v = 8'($urandom);
      while (v == cur_cfg.start_byte || v == cur_cfg.end_byte ||
             v == cur_cfg.escape_byte);
      return v;
   endfunction

   // The result side: ready drops for random stretches, except in quiet phases.
   initial begin : result_drain
      int n;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
   end

   // Every result beat taken is checked against the oldest owed decode.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result({rsp_data_valid, rsp_data_byte, rsp_data_index,
                               rsp_frame_done, rsp_frame_kind, rsp_status});
   end

   // Present one raw byte and hold it until the beat is taken. Valid stays
   // high from one beat to the next when there is no gap, so it is never
   // lowered and raised in the same step.
   task automatic send_byte(input logic [7:0] b);
      int idle;
      idle = pick_gap();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      tracker.note_raw_byte(b);
   endtask

   // Always exactly RAW_LEN beats, so the chunk boundaries stay aligned: a
   // long body is cut short and a short one is padded with random bytes.
   task automatic send_chunk(input byte_queue_type body);
      logic [7:0] b;
      for (int i = 0; i < RAW_LEN; i++) begin
         b = (i < body.size()) ? body[i] : 8'($urandom);
         send_byte(b);
      end
      chunks_sent++;
   endtask

   // Stop sending and wait until every owed result has been taken. A byte
   // that causes no result may still be in flight, so the task waits on past
   // the last owed result before it returns.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all four registers on consecutive edges; only done while idle.
   task automatic write_settings(input cfg_type c);
      csr_index_type idx;
      logic [7:0]    v;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_START_BYTE:  v = c.start_byte;
            CSR_END_BYTE:    v = c.end_byte;
            CSR_ESCAPE_BYTE: v = c.escape_byte;
            default:         v = c.xor_mask;
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v;
         @(posedge clock);
         tracker.write_reg(idx, v);
      end
      csr_we  <= 1'b0;
      cur_cfg  = c;
      settings_used++;
   endtask

   // Hand-built chunks, run under the register values left by reset.
   task automatic run_directed();
      byte_queue_type body;
      logic [7:0]     s, e, x;
      s = cur_cfg.start_byte;
      e = cur_cfg.end_byte;
      x = cur_cfg.escape_byte;

      // Bad first byte: the whole chunk is ignored and reported as such.
      body = {~s};
      send_chunk(body);

      // Start byte turning up inside the payload.
      body = {s, 8'hFF, 8'h00, 8'h5A, s};
      send_chunk(body);

      // Escaped start, end and escape bytes are all decoded and emitted.
      body = {s, 8'h00, x, s, x, e, x, x, 8'hFF, 8'h00, e};
      send_chunk(body);

      // One payload byte more than the limit.
      body = {s, 8'hA5};
      repeat (PAYLOAD_MAX + 1) body.push_back(plain_byte());
      send_chunk(body);

      // No end byte, every index reached through escapes, and an escape
      // left pending on the last byte of the chunk.
      body = {s, 8'h3C};
      repeat (PAYLOAD_MAX) begin
         body.push_back(x);
         body.push_back(8'($urandom));
      end
      body.push_back(x);
      send_chunk(body);

      // Full payload, then a plain byte as the last beat: it overflows and
      // the frame report rides on the same beat.
      body = {s, 8'hC3};
      repeat (PAYLOAD_MAX) begin
         body.push_back(x);
         body.push_back(8'($urandom));
      end
      body.push_back(plain_byte());
      send_chunk(body);

      // Full payload closed by an end byte that is also the last beat.
      body = {s, 8'h7E};
      repeat (PAYLOAD_MAX) begin
         body.push_back(x);
         body.push_back(plain_byte());
      end
      body.push_back(e);
      send_chunk(body);

      // Type byte equal to the start byte, and an empty payload.
      body = {s, s, e};
      send_chunk(body);
   endtask

   // Mostly well-formed frames with random content; some broken ones and
   // some pure noise.
   task automatic send_random_chunk();
      byte_queue_type body;
      int             kind;
      int             n;
      logic [7:0]     b;
      kind = $urandom_range(0, 99);
      body = {};
      if (kind >= 90) begin
         repeat (RAW_LEN) body.push_back(8'($urandom));
      end else if (kind >= 80) begin
         b = 8'($urandom);
         if (b == cur_cfg.start_byte)
            b = ~b;
         body.push_back(b);
      end else begin
         body.push_back(cur_cfg.start_byte);
         body.push_back(8'($urandom));
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(PAYLOAD_MAX + 1, 40)
                                         : $urandom_range(0, PAYLOAD_MAX);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               body.push_back(cur_cfg.escape_byte);
               body.push_back(8'($urandom));
            end else begin
               body.push_back(plain_byte());
            end
         end
         // Close with the end byte, leave it open, or break it with a start.
         if (kind < 65)
            body.push_back(cur_cfg.end_byte);
         else if (kind >= 72)
            body.push_back(cur_cfg.start_byte);
      end
      send_chunk(body);
   endtask

   initial begin : stimulus
      cfg_type c;
      int      phase_no;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random part: one chunk per register setting, with the extremes
      // visited in turn, until about 1150 raw bytes have been sent.
      phase_no = 0;
      while (tracker.raw_bytes + RAW_LEN / 2 < 1150) begin
         settle();
         case (phase_no % 5)
            0:       c = {8'h00, 8'hFF, 8'h80, 8'hFF};
            1:       c = {8'hFF, 8'h00, 8'h01, 8'h00};
            2:       c = {8'h7E, 8'h7D, 8'h7D, 8'h55};  // end and escape coincide
            3:       c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            default: c = {START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, XOR_MASK_RST};
         endcase
         write_settings(c);
         quiet = (phase_no % 4 == 3);
         // Now and then the sender holds off until everything has drained.
         if ($urandom_range(0, 3) == 0)
            settle();
         send_random_chunk();
         phase_no++;
      end

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      tracker.close_out();

      $display("Run covered %0d raw bytes (%0d decoded) in %0d chunks under %0d settings.",
               tracker.raw_bytes, tracker.decoded_bytes, chunks_sent, settings_used);
      $display("Checked %0d payload beats, %0d frame reports (%0d/%0d/%0d/%0d by status).",
               tracker.data_beats, tracker.frame_reports, tracker.status_count[ST_OK],
               tracker.status_count[ST_BAD_START],
               tracker.status_count[ST_START_IN_PAYLOAD],
               tracker.status_count[ST_OVERFLOW]);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
